// File: rtl/core/amtd_pkg.sv
// amtd_pkg: shared types, constants and register codes for the tamper detector
// used by every module under rtl/core, no dependencies of its own
package amtd_pkg;

  localparam int AMTD_BLOCK_LEN   = 10;
  localparam int AMTD_SAMPLE_BITS = 16;
  localparam int AMTD_LANES       = 3;

  localparam int THR_W      = 17;
  localparam int HOLD_W     = 16;
  localparam int WARM_W     = 4;
  localparam int WARM_CNT_W = WARM_W + 1;
  localparam int DIFF_W     = 17;

  localparam logic [THR_W-1:0]      THR_RESET  = THR_W'(100);
  localparam logic [HOLD_W-1:0]     HOLD_RESET = HOLD_W'(6000);
  localparam logic [WARM_W-1:0]     WARM_RESET = WARM_W'(3);
  localparam logic [WARM_CNT_W-1:0] WARM_CNT_RESET = WARM_CNT_W'(3);
  localparam logic [DIFF_W-1:0]     DIFF_MAX   = '1;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MOTION_THRESHOLD = 2'd0,
    CFG_HOLDOFF_BLOCKS   = 2'd1,
    CFG_WARMUP_BLOCKS    = 2'd2
  } cfg_idx_t;

  // result beat layout in out_tdata
  localparam int OUT_ARMED_BIT = 0;
  localparam int OUT_LED_BIT   = 1;
  localparam int OUT_DIFF_LSB  = 2;
  localparam int OUT_ALARM_BIT = OUT_DIFF_LSB + DIFF_W;
  localparam int OUT_TDATA_W   = ((OUT_ALARM_BIT + 1 + 7) / 8) * 8;

  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
    logic in_done;
    logic s2_done;
  } lane_ctrl_t;

  typedef struct packed {
    logic              armed;
    logic              led_on;
    logic              block_done;
    logic [DIFF_W-1:0] block_difference;
    logic              alarm;
  } amtd_result_t;

endpackage

// File: rtl/core/amtd_lane.sv
// amtd_lane: one axis lane - block accumulator, reciprocal divide, abs difference
// depends on amtd_pkg
module amtd_lane import amtd_pkg::*; #(
  parameter int BLOCK_LEN   = AMTD_BLOCK_LEN,
  parameter int SAMPLE_BITS = AMTD_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lane_ctrl_t                    ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic        [SAMPLE_BITS-1:0] absdiff
);

  localparam int SUM_W   = SAMPLE_BITS + $clog2(BLOCK_LEN);
  localparam int SHIFT   = SUM_W + $clog2(BLOCK_LEN);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic signed [SUM_W-1:0]       sum_r;
  logic signed [SUM_W-1:0]       sum_nxt;
  logic        [SUM_W-1:0]       mag_r;
  logic        [SUM_W-1:0]       mag_nxt;
  logic        [PROD_W-1:0]      prod;
  logic        [SAMPLE_BITS-1:0] quo_r;
  logic        [SAMPLE_BITS-1:0] last_r;
  logic        [SAMPLE_BITS-1:0] diff_r;
  logic        [SAMPLE_BITS-1:0] diff_nxt;

  always_comb begin
    sum_nxt = sum_r + {{(SUM_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    mag_nxt = sum_nxt[SUM_W-1] ? (~$unsigned(sum_nxt) + 1'b1) : $unsigned(sum_nxt);
  end

  // floor(|sum| / BLOCK_LEN) as multiply by rounded-up reciprocal
  assign prod = PROD_W'(mag_r) * PROD_W'(RECIP);

  always_comb begin
    diff_nxt = (quo_r > last_r) ? (quo_r - last_r) : (last_r - quo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      last_r <= '0;
    end else begin
      if (ctrl.adv1) begin
        sum_r <= ctrl.in_done ? '0 : sum_nxt;
      end
      if (ctrl.adv3 && ctrl.s2_done) begin
        last_r <= quo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv1) begin
      mag_r <= mag_nxt;
    end
    if (ctrl.adv2) begin
      quo_r <= prod[SHIFT +: SAMPLE_BITS];
    end
    if (ctrl.adv3) begin
      diff_r <= diff_nxt;
    end
  end

  assign absdiff = diff_r;

endmodule

// File: rtl/core/amtd_merge.sv
// amtd_merge: sums lane differences, runs arming, warm-up and hold-off, holds result beat
// depends on amtd_pkg
module amtd_merge import amtd_pkg::*; #(
  parameter int SAMPLE_BITS = AMTD_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   done,
  input  logic                   button,
  input  logic [SAMPLE_BITS-1:0] lane_diff [AMTD_LANES],
  input  logic [THR_W-1:0]       thr,
  input  logic [HOLD_W-1:0]      hold_cfg,
  input  logic [WARM_W-1:0]      warm_cfg,
  input  logic                   out_ready,
  output logic                   out_valid,
  output amtd_result_t           result
);

  localparam int SUMD_W = SAMPLE_BITS + 2;
  localparam int CMP_W  = (SUMD_W > DIFF_W) ? SUMD_W : DIFF_W;

  logic [SUMD_W-1:0]     dsum;
  logic [CMP_W-1:0]      dwide;
  logic [DIFF_W-1:0]     dsat;
  logic                  over;
  logic                  valid_r;
  logic                  valid_nxt;
  logic                  armed_r, armed_nxt;
  logic                  led_r, led_nxt;
  logic [WARM_CNT_W-1:0] warm_r, warm_nxt, warm_b;
  logic [HOLD_W-1:0]     hold_r, hold_nxt, hold_b;
  logic                  alarm_nxt;
  amtd_result_t          res_r;

  always_comb begin
    dsum  = SUMD_W'(lane_diff[0]) + SUMD_W'(lane_diff[1]) + SUMD_W'(lane_diff[2]);
    dwide = done ? CMP_W'(dsum) : '0;
    over  = dwide > CMP_W'(thr);
    dsat  = (dwide > CMP_W'(DIFF_MAX)) ? DIFF_MAX : dwide[DIFF_W-1:0];
  end

  always_comb begin
    armed_nxt = armed_r ^ button;
    led_nxt   = led_r ^ button;
    warm_b    = button ? {1'b0, warm_cfg} : warm_r;
    hold_b    = button ? '0 : hold_r;
    warm_nxt  = warm_b;
    hold_nxt  = hold_b;
    alarm_nxt = 1'b0;
    if (done && armed_nxt) begin
      // sign bit set means warm-up over, counter sits at -1
      if (!warm_b[WARM_CNT_W-1]) begin
        warm_nxt = warm_b - 1'b1;
      end
      if (warm_b[WARM_CNT_W-1] && over) begin
        if (hold_b == '0) begin
          alarm_nxt = 1'b1;
          hold_nxt  = hold_cfg;
        end else begin
          hold_nxt = hold_b - 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      armed_r <= 1'b0;
      led_r   <= 1'b0;
      warm_r  <= WARM_CNT_RESET;
      hold_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        armed_r <= armed_nxt;
        led_r   <= led_nxt;
        warm_r  <= warm_nxt;
        hold_r  <= hold_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.armed            <= armed_nxt;
      res_r.led_on           <= led_nxt;
      res_r.block_done       <= done;
      res_r.block_difference <= dsat;
      res_r.alarm            <= alarm_nxt;
    end
  end

  assign out_valid = valid_r;
  assign result    = res_r;

endmodule

// File: rtl/core/armed_motion_tamper_detector.sv
// armed_motion_tamper_detector: top level - config registers, beat pipeline control,
// three axis lanes and the merge stage; depends on amtd_pkg, amtd_lane, amtd_merge
//
// Takes one accelerometer beat per clock while the result side keeps up and returns exactly one
// result beat for each, presented once it has passed the accumulate, multiply, difference and merge
// registers. Sustained rate is one beat per cycle unless out_tready stalls the pipeline; the depth
// is set by the per-axis accumulate, reciprocal multiply and difference stages plus the merge stage
// that holds the result. Every BLOCK_LEN beats a result carries tlast with the block difference;
// alarms need the detector armed by a button press and the warm-up count spent. Config writes take
// effect the next cycle and are meant for idle periods only.
module armed_motion_tamper_detector import amtd_pkg::*; #(
  parameter int BLOCK_LEN   = AMTD_BLOCK_LEN,
  parameter int SAMPLE_BITS = AMTD_SAMPLE_BITS,
  localparam int IN_TDATA_W = ((1 + AMTD_LANES * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // button_pressed, accel_x, accel_y, accel_z; zero pad above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // armed, led_on, block_difference, alarm; zero pad above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // block_done
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(BLOCK_LEN);

  logic [THR_W-1:0]       thr_r;
  logic [HOLD_W-1:0]      hold_cfg_r;
  logic [WARM_W-1:0]      warm_cfg_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   v1_r, v2_r, v3_r;
  logic                   btn1_r, btn2_r, btn3_r;
  logic                   done1_r, done2_r, done3_r;
  logic                   adv_out;
  logic                   in_done;
  logic                   merge_valid;
  lane_ctrl_t             lctrl;
  logic [SAMPLE_BITS-1:0] lane_diff [AMTD_LANES];
  amtd_result_t           res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RESET;
      hold_cfg_r <= HOLD_RESET;
      warm_cfg_r <= WARM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MOTION_THRESHOLD: thr_r      <= cfg_wdata[THR_W-1:0];
        CFG_HOLDOFF_BLOCKS:   hold_cfg_r <= cfg_wdata[HOLD_W-1:0];
        CFG_WARMUP_BLOCKS:    warm_cfg_r <= cfg_wdata[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  // each stage moves when the next one is empty or moving
  always_comb begin
    in_done      = (cnt_r == CNT_W'(BLOCK_LEN - 1));
    adv_out      = v3_r && (!merge_valid || out_tready);
    lctrl.adv3   = v2_r && (!v3_r || adv_out);
    lctrl.adv2   = v1_r && (!v2_r || lctrl.adv3);
    in_tready    = !v1_r || lctrl.adv2;
    lctrl.adv1   = in_tvalid && in_tready;
    lctrl.in_done = in_done;
    lctrl.s2_done = done2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (lctrl.adv1) begin
        cnt_r <= in_done ? '0 : cnt_r + 1'b1;
      end
      v1_r <= lctrl.adv1 || (v1_r && !lctrl.adv2);
      v2_r <= lctrl.adv2 || (v2_r && !lctrl.adv3);
      v3_r <= lctrl.adv3 || (v3_r && !adv_out);
    end
  end

  always_ff @(posedge clk) begin
    if (lctrl.adv1) begin
      btn1_r  <= in_tdata[0];
      done1_r <= in_done;
    end
    if (lctrl.adv2) begin
      btn2_r  <= btn1_r;
      done2_r <= done1_r;
    end
    if (lctrl.adv3) begin
      btn3_r  <= btn2_r;
      done3_r <= done2_r;
    end
  end

  for (genvar i = 0; i < AMTD_LANES; i++) begin : g_lane
    amtd_lane #(
      .BLOCK_LEN   (BLOCK_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lctrl),
      .sample  ($signed(in_tdata[1 + i*SAMPLE_BITS +: SAMPLE_BITS])),
      .absdiff (lane_diff[i])
    );
  end

  amtd_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv_out),
    .done      (done3_r),
    .button    (btn3_r),
    .lane_diff (lane_diff),
    .thr       (thr_r),
    .hold_cfg  (hold_cfg_r),
    .warm_cfg  (warm_cfg_r),
    .out_ready (out_tready),
    .out_valid (merge_valid),
    .result    (res)
  );

  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_ARMED_BIT] = res.armed;
    out_tdata[OUT_LED_BIT]   = res.led_on;
    out_tdata[OUT_DIFF_LSB +: DIFF_W] = res.block_difference;
    out_tdata[OUT_ALARM_BIT] = res.alarm;
  end

  assign out_tlast  = res.block_done;
  assign out_tvalid = merge_valid;

endmodule

// File: rtl/core/amtd_checker.sv
// amtd_checker: port-level checks on the result stream, bound to the top level
// depends on amtd_pkg and armed_motion_tamper_detector
module amtd_checker import amtd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // no block end means no difference and no alarm
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      out_tdata[OUT_DIFF_LSB +: DIFF_W] == '0 && !out_tdata[OUT_ALARM_BIT])
    else $error("difference or alarm outside a block end");

  // alarm only while armed
  a_alarm_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_ALARM_BIT] |-> out_tdata[OUT_ARMED_BIT])
    else $error("alarm raised while disarmed");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind armed_motion_tamper_detector amtd_checker u_amtd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: test/tb_armed_motion_tamper_detector.sv
// tb_armed_motion_tamper_detector: self-checking bench for the armed motion tamper detector
// drives sample beats with bursty pacing and a stalling result sink; most directed rows carry typed
// results, every other beat is predicted in-bench; depends on amtd_pkg and the armed_motion_tamper_detector top level
module tb_armed_motion_tamper_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import amtd_pkg::*;

  localparam int IN_W = ((1 + AMTD_LANES * AMTD_SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int DIR_ROWS = 24;
  localparam int STALL_PHASE = 2;
  localparam int PAUSE_PHASE = 3;

  typedef logic signed [AMTD_SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic    btn;
    sample_t x;
    sample_t y;
    sample_t z;
  } accel_beat_t;

  typedef struct {
    logic              btn;
    sample_t           x;
    sample_t           y;
    sample_t           z;
    bit                typed;
    logic              armed;
    logic              led_on;
    logic              block_done;
    logic [DIFF_W-1:0] block_difference;
    logic              alarm;
  } dir_row_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_PATTERN} sink_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  // button_pressed, accel_x, accel_y, accel_z; zero pad above
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // armed, led_on, block_difference, alarm; zero pad above
  logic [OUT_TDATA_W-1:0] out_tdata;
  // block_done
  logic out_tlast;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  armed_motion_tamper_detector dut (
    .clk, .rst_n,
    .in_tdata, .in_tvalid, .in_tready,
    .out_tdata, .out_tlast, .out_tvalid, .out_tready,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  // predictor state and register copy
  longint axis_acc[3];
  longint prev_avg[3];
  int samples_in_block;
  bit armed_q, led_q;
  int warm_left;
  logic [HOLD_W-1:0] hold_left;
  logic [THR_W-1:0] thr_q;
  logic [HOLD_W-1:0] hold_cfg;
  logic [WARM_W-1:0] warm_cfg;

  amtd_result_t expected_results[$];
  dir_row_t dir_rows[DIR_ROWS];
  int fails = 0;
  int burst_left = 0;
  bit long_stall_req = 0;
  bit long_stall_on = 0;

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic amtd_result_t detector_step(accel_beat_t b);
    amtd_result_t r;
    longint smp[3];
    longint avg;
    longint diff;
    bit warm;
    r = '0;
    diff = 0;
    smp[0] = b.x;
    smp[1] = b.y;
    smp[2] = b.z;
    if (b.btn) begin
      led_q = ~led_q;
      armed_q = ~armed_q;
      warm_left = int'(warm_cfg);
      hold_left = '0;
    end
    for (int i = 0; i < AMTD_LANES; i++) axis_acc[i] += smp[i];
    samples_in_block++;
    if (samples_in_block >= AMTD_BLOCK_LEN) begin
      r.block_done = 1'b1;
      samples_in_block = 0;
      for (int i = 0; i < AMTD_LANES; i++) begin
        avg = axis_acc[i] / longint'(AMTD_BLOCK_LEN);
        axis_acc[i] = 0;
        diff += abs_l(abs_l(avg) - abs_l(prev_avg[i]));
        prev_avg[i] = avg;
      end
      if (armed_q) begin
        warm = warm_left < 0;
        if (warm_left >= 0) warm_left--;
        if (warm && diff > longint'(thr_q)) begin
          if (hold_left == '0) begin
            r.alarm = 1'b1;
            hold_left = hold_cfg;
          end else begin
            hold_left--;
          end
        end
      end
    end
    r.armed = armed_q;
    r.led_on = led_q;
    r.block_difference = (diff > longint'(DIFF_MAX)) ? DIFF_MAX : DIFF_W'(diff);
    return r;
  endfunction

  function automatic sample_t pick_sample(int bias);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 3) return sample_t'($urandom);
    if (mode < 5) begin
      case ($urandom_range(0, 3))
        0: return sample_t'(16'h7fff);
        1: return sample_t'(16'h8000);
        2: return sample_t'(0);
        default: return sample_t'(-1);
      endcase
    end
    return sample_t'(bias + int'($urandom_range(0, 128)) - 64);
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] hold,
                              logic [CFG_DATA_W-1:0] warm);
    cfg_write(CFG_MOTION_THRESHOLD, thr);
    cfg_write(CFG_HOLDOFF_BLOCKS, hold);
    cfg_write(CFG_WARMUP_BLOCKS, warm);
    cfg_write(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    thr_q = thr[THR_W-1:0];
    hold_cfg = hold[HOLD_W-1:0];
    warm_cfg = warm[WARM_W-1:0];
  endtask

  task automatic offer(accel_beat_t b, bit typed, amtd_result_t typed_want);
    amtd_result_t pred;
    in_tdata <= IN_W'({b.z, b.y, b.x, b.btn});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = detector_step(b);
    expected_results.push_back(typed ? typed_want : pred);
  endtask

  task automatic pace(bit drain);
    int gap;
    if (long_stall_on) begin
      gap = 0;
    end else if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(1, 12);
    end
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && expected_results.size() != 0) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    amtd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        want = expected_results.pop_front();
        check_field("armed", want.armed, out_tdata[OUT_ARMED_BIT]);
        check_field("led_on", want.led_on, out_tdata[OUT_LED_BIT]);
        check_field("block_done", want.block_done, out_tlast);
        check_field("block_difference", want.block_difference,
                    out_tdata[OUT_DIFF_LSB +: DIFF_W]);
        check_field("alarm", want.alarm, out_tdata[OUT_ALARM_BIT]);
      end
    end
  end

  initial begin : result_sink
    sink_mode_t mode;
    int mode_left;
    logic [7:0] pat;
    int k;
    mode = SINK_OPEN;
    mode_left = 0;
    pat = '1;
    k = 0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 0;
        long_stall_on = 1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_stall_on = 0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 64);
          pat = 8'($urandom);
        end
        mode_left--;
        k++;
        case (mode)
          SINK_OPEN: out_tready <= 1'b1;
          SINK_COIN: out_tready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= pat[k % 8];
        endcase
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_armed_motion_tamper_detector: errors");
    $finish;
  end

  initial begin : stimulus
    accel_beat_t beat;
    amtd_result_t want;
    int bias;
    logic [CFG_DATA_W-1:0] thr_set[NUM_PHASES];
    logic [CFG_DATA_W-1:0] hold_set[NUM_PHASES];
    logic [CFG_DATA_W-1:0] warm_set[NUM_PHASES];

    for (int i = 0; i < AMTD_LANES; i++) begin
      axis_acc[i] = 0;
      prev_avg[i] = 0;
    end
    samples_in_block = 0;
    armed_q = 0;
    led_q = 0;
    warm_left = 3;
    hold_left = '0;
    thr_q = THR_RESET;
    hold_cfg = HOLD_RESET;
    warm_cfg = WARM_RESET;

    thr_set = '{17'd100, 17'd0, 17'd98301, 17'd2000, 17'd50,
                CFG_DATA_W'($urandom_range(0, 20000))};
    hold_set = '{17'd6000, 17'd0, 17'd65535, 17'h1_0005, 17'd3,
                 CFG_DATA_W'($urandom_range(0, 10))};
    warm_set = '{17'd3, 17'd0, 17'd15, 17'h1_fff3, 17'd1,
                 CFG_DATA_W'($urandom_range(0, 15))};

    // disarmed block of extremes, press, armed block in warm-up, double press
    dir_rows[0]  = '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[1]  = '{1'b0, 16'h7fff, 16'h8000, 16'h7fff, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[2]  = '{1'b0, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[3]  = '{1'b0, 16'hffff, 16'h0001, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[4]  = '{1'b0, 16'h5555, 16'haaaa, 16'h5555, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[5]  = '{1'b0, 16'haaaa, 16'h5555, 16'haaaa, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[6]  = '{1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[7]  = '{1'b0, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[8]  = '{1'b0, 16'h0001, 16'hffff, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[9]  = '{1'b0, 16'h7fff, 16'h8000, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[10] = '{1'b1, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[11] = '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[12] = '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[13] = '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[14] = '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[15] = '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[16] = '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[17] = '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[18] = '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[19] = '{1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[20] = '{1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0};
    dir_rows[21] = '{1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[22] = '{1'b0, 16'h1234, 16'hedcb, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};
    dir_rows[23] = '{1'b0, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      beat = '{dir_rows[r].btn, dir_rows[r].x, dir_rows[r].y, dir_rows[r].z};
      want = '{dir_rows[r].armed, dir_rows[r].led_on, dir_rows[r].block_done,
               dir_rows[r].block_difference, dir_rows[r].alarm};
      offer(beat, dir_rows[r].typed, want);
      pace(1'b0);
    end

    bias = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      // the first phase keeps the reset register values
      if (p > 0) program_regs(thr_set[p], hold_set[p], warm_set[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % AMTD_BLOCK_LEN == 0) bias = int'($urandom_range(0, 40000)) - 20000;
        beat.btn = ($urandom_range(0, 39) == 0);
        beat.x = pick_sample(bias);
        beat.y = pick_sample(bias);
        beat.z = pick_sample(bias);
        if (p == STALL_PHASE && i == 20) long_stall_req = 1;
        offer(beat, 1'b0, '0);
        pace(i == PHASE_ITEMS - 1 || (p == PAUSE_PHASE && i == PHASE_ITEMS / 2));
      end
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (fails == 0 && expected_results.size() == 0) begin
      $display("tb_armed_motion_tamper_detector: clean");
    end else begin
      $display("tb_armed_motion_tamper_detector: errors");
    end
    $finish;
  end

endmodule
